// ===== hdl/slpm_pkg.sv =====
// shared types, codes and morse tables for the status led pattern block
`timescale 1ns / 1ps
package slpm_pkg;

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_SET  = 2'd1,
		MODE_SHOW = 2'd2,
		MODE_RSVD = 2'd3
	} mode_t;

	localparam logic [3:0] PAT_OFF         = 4'd0;
	localparam logic [3:0] PAT_SOLID       = 4'd1;
	localparam logic [3:0] PAT_SLOW        = 4'd2;
	localparam logic [3:0] PAT_FAST        = 4'd3;
	localparam logic [3:0] PAT_DOUBLE      = 4'd4;
	localparam logic [3:0] PAT_TRIPLE      = 4'd5;
	localparam logic [3:0] PAT_HEARTBEAT   = 4'd6;
	localparam logic [3:0] PAT_ERROR       = 4'd7;
	localparam logic [3:0] PAT_FINGERPRINT = 4'd8;

	localparam logic [6:0] DIT_TICKS  = 7'd10;
	localparam logic [6:0] DAH_TICKS  = 7'd30;
	localparam logic [6:0] SYM_GAP    = 7'd10;
	localparam logic [6:0] CHAR_GAP   = 7'd30;
	localparam logic [6:0] FINAL_GAP  = 7'd70;

	typedef enum logic [2:0] {
		SEG_ON        = 3'd0,
		SEG_SYM_GAP   = 3'd1,
		SEG_CHAR_GAP  = 3'd2,
		SEG_FINAL_GAP = 3'd3,
		SEG_DONE      = 3'd4
	} seg_t;

	typedef struct packed {
		logic phase_clr;
		logic phase_step;
		logic fp_load;
		logic fp_step;
	} ctrl_t;

	// symbol bits per nibble, 1 = dah, sent from bit len-1 down to 0
	function automatic logic [4:0] morse_code(input logic [3:0] nib);
		logic [4:0] c;
		unique case (nib)
			4'h0: c = 5'h1F;
			4'h1: c = 5'h0F;
			4'h2: c = 5'h07;
			4'h3: c = 5'h03;
			4'h4: c = 5'h01;
			4'h5: c = 5'h00;
			4'h6: c = 5'h10;
			4'h7: c = 5'h18;
			4'h8: c = 5'h1C;
			4'h9: c = 5'h1E;
			4'hA: c = 5'h01;
			4'hB: c = 5'h08;
			4'hC: c = 5'h0A;
			4'hD: c = 5'h04;
			4'hE: c = 5'h00;
			4'hF: c = 5'h02;
			default: c = 5'h00;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] morse_len(input logic [3:0] nib);
		logic [2:0] n;
		unique case (nib)
			4'hA: n = 3'd2;
			4'hB: n = 3'd4;
			4'hC: n = 3'd4;
			4'hD: n = 3'd3;
			4'hE: n = 3'd1;
			4'hF: n = 3'd4;
			default: n = 3'd5;
		endcase
		return n;
	endfunction

endpackage

// ===== hdl/slpm_pattern_gen.sv =====
// phase counters and periodic blink pattern decode
`timescale 1ns / 1ps
module slpm_pattern_gen (
	input  logic           clk,
	input  logic           arst_n,
	input  slpm_pkg::ctrl_t ctrl,
	input  logic [3:0]     pattern,
	input  logic           held_level,
	output logic           level
);
	import slpm_pkg::*;

	// phase modulo each pattern period, all restart together
	logic [7:0] c200_q;
	logic [5:0] c40_q;
	logic [8:0] c300_q;
	logic [6:0] c120_q;
	logic [4:0] c30_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c200_q <= '0;
			c40_q  <= '0;
			c300_q <= '0;
			c120_q <= '0;
			c30_q  <= '0;
		end else if (ctrl.phase_clr) begin
			c200_q <= '0;
			c40_q  <= '0;
			c300_q <= '0;
			c120_q <= '0;
			c30_q  <= '0;
		end else if (ctrl.phase_step) begin
			c200_q <= (c200_q == 8'd199) ? 8'd0 : c200_q + 8'd1;
			c40_q  <= (c40_q == 6'd39) ? 6'd0 : c40_q + 6'd1;
			c300_q <= (c300_q == 9'd299) ? 9'd0 : c300_q + 9'd1;
			c120_q <= (c120_q == 7'd119) ? 7'd0 : c120_q + 7'd1;
			c30_q  <= (c30_q == 5'd29) ? 5'd0 : c30_q + 5'd1;
		end
	end

	always_comb begin
		unique case (pattern)
			PAT_SOLID:       level = 1'b1;
			PAT_SLOW:        level = c200_q < 8'd20;
			PAT_FAST:        level = c40_q < 6'd20;
			PAT_DOUBLE:      level = c200_q < 8'd20 || (c200_q >= 8'd40 && c200_q < 8'd60);
			PAT_TRIPLE:      level = c300_q < 9'd20 || (c300_q >= 9'd40 && c300_q < 9'd60)
				|| (c300_q >= 9'd80 && c300_q < 9'd100);
			PAT_HEARTBEAT:   level = c120_q < 7'd10 || (c120_q >= 7'd20 && c120_q < 7'd30);
			PAT_ERROR:       level = c30_q < 5'd15;
			PAT_FINGERPRINT: level = held_level;
			default:         level = 1'b0;
		endcase
	end

endmodule

// ===== hdl/slpm_morse_seq.sv =====
// morse cursor: nibble shift register, symbol index and segment timer
`timescale 1ns / 1ps
module slpm_morse_seq #(
	parameter int FP_BYTES = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  slpm_pkg::ctrl_t ctrl,
	input  logic [31:0]     fingerprint,
	output logic            level,
	output logic            done
);
	import slpm_pkg::*;

	localparam int SH_W   = 8 * FP_BYTES;
	localparam int NIBS   = 2 * FP_BYTES;
	localparam int NIB_W  = $clog2(NIBS);

	logic [SH_W-1:0]  sh_q;
	logic [NIB_W-1:0] nib_left_q;
	logic [2:0]       sym_q;
	seg_t             seg_q;
	logic [6:0]       cnt_q;

	logic [SH_W-1:0]  load_val;
	logic [4:0]       code;
	logic [7:0]       code_ext;
	logic [6:0]       seg_len;
	logic             seg_end;
	logic [3:0]       next_nib;

	generate
		if (FP_BYTES < 4) begin : g_narrow
			assign load_val = fingerprint[31 -: SH_W];
		end else if (FP_BYTES == 4) begin : g_exact
			assign load_val = fingerprint;
		end else begin : g_wide
			assign load_val = {fingerprint, {(SH_W-32){1'b0}}};
		end
	endgenerate

	assign code     = morse_code(sh_q[SH_W-1 -: 4]);
	assign code_ext = {3'b000, code};
	assign next_nib = sh_q[SH_W-5 -: 4];

	always_comb begin
		unique case (seg_q)
			SEG_ON:        seg_len = code_ext[sym_q] ? DAH_TICKS : DIT_TICKS;
			SEG_SYM_GAP:   seg_len = SYM_GAP;
			SEG_CHAR_GAP:  seg_len = CHAR_GAP;
			SEG_FINAL_GAP: seg_len = FINAL_GAP;
			default:       seg_len = FINAL_GAP;
		endcase
	end

	assign seg_end = (cnt_q == seg_len - 7'd1);
	assign level   = (seg_q == SEG_ON);
	assign done    = (seg_q == SEG_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q       <= '0;
			nib_left_q <= '0;
			sym_q      <= '0;
			seg_q      <= SEG_DONE;
			cnt_q      <= '0;
		end else if (ctrl.fp_load) begin
			sh_q       <= load_val;
			nib_left_q <= NIB_W'(NIBS - 1);
			sym_q      <= morse_len(load_val[SH_W-1 -: 4]) - 3'd1;
			seg_q      <= SEG_ON;
			cnt_q      <= '0;
		end else if (ctrl.fp_step && seg_q != SEG_DONE) begin
			if (!seg_end) begin
				cnt_q <= cnt_q + 7'd1;
			end else begin
				cnt_q <= '0;
				unique case (seg_q)
					SEG_ON: begin
						seg_q <= SEG_SYM_GAP;
					end
					SEG_SYM_GAP: begin
						if (sym_q == 3'd0) begin
							seg_q <= SEG_CHAR_GAP;
						end else begin
							sym_q <= sym_q - 3'd1;
							seg_q <= SEG_ON;
						end
					end
					SEG_CHAR_GAP: begin
						if (nib_left_q == '0) begin
							seg_q <= SEG_FINAL_GAP;
						end else begin
							sh_q       <= sh_q << 4;
							nib_left_q <= nib_left_q - NIB_W'(1);
							sym_q      <= morse_len(next_nib) - 3'd1;
							seg_q      <= SEG_ON;
						end
					end
					default: begin
						seg_q <= SEG_DONE;
					end
				endcase
			end
		end
	end

endmodule

// ===== hdl/status_led_pattern_morse.sv =====
// top level of the status led driver with morse fingerprint playback
//
// input stream s_*: one item per transfer, s_tdata holds mode [1:0],
// pattern [5:2] and fingerprint [37:6]. mode 0 is a tick, 1 sets the
// blink pattern, 2 starts fingerprint playback, 3 is ignored.
// output stream m_*: one transfer per tick only, m_tdata holds led_pin [0]
// and fingerprint_active [1]. commands give no transfer.
// cfg_we/cfg_wdata write the led polarity (1 = on drives high).
// a tick's input transfer loads the input register; its decode and state
// update load the output register once the output can advance.
// throughput: one item per cycle while the receiver does not stall.
// reset: pattern off, phase zero, no playback, polarity active high.
// when the receiver stalls, the output register holds its result, the input
// register takes one more item if it is empty, and then s_tready drops until
// the result is taken.
`timescale 1ns / 1ps
module status_led_pattern_morse #(
	parameter int FP_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,    // mode, pattern, fingerprint, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata     // led_pin, fingerprint_active, zero pad
);
	import slpm_pkg::*;

	logic        valid_s1;
	mode_t       mode_s1;
	logic [3:0]  pattern_s1;
	logic [31:0] fp_s1;

	logic        active_high_q;
	logic [3:0]  cur_pat_q;
	logic [3:0]  saved_pat_q;
	logic        playing_q;
	logic        led_q;

	logic        m_valid_q;
	logic        led_pin_q;
	logic        fp_active_q;

	logic        advance;
	logic        fire;
	logic        is_tick;
	ctrl_t       ctrl;
	logic        pat_level;
	logic        morse_level;
	logic        morse_done;
	logic        led_next;
	logic        playing_next;

	assign advance  = !m_valid_q || m_tready;
	assign s_tready = advance || !valid_s1;
	assign fire     = valid_s1 && advance;
	assign is_tick  = fire && mode_s1 == MODE_TICK;

	assign ctrl.phase_clr  = fire && mode_s1 == MODE_SET;
	assign ctrl.phase_step = is_tick && !playing_q;
	assign ctrl.fp_load    = fire && mode_s1 == MODE_SHOW;
	assign ctrl.fp_step    = is_tick && playing_q && !morse_done;

	slpm_pattern_gen u_pattern (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.pattern    (cur_pat_q),
		.held_level (led_q),
		.level      (pat_level)
	);

	slpm_morse_seq #(
		.FP_BYTES (FP_BYTES)
	) u_morse (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.fingerprint (fp_s1),
		.level       (morse_level),
		.done        (morse_done)
	);

	always_comb begin
		if (playing_q) begin
			led_next     = morse_done ? 1'b0 : morse_level;
			playing_next = !morse_done;
		end else begin
			led_next     = pat_level;
			playing_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1    <= mode_t'(s_tdata[1:0]);
			pattern_s1 <= s_tdata[5:2];
			fp_s1      <= s_tdata[37:6];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q <= 1'b1;
		end else if (cfg_we) begin
			active_high_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pat_q   <= PAT_OFF;
			saved_pat_q <= PAT_OFF;
			playing_q   <= 1'b0;
			led_q       <= 1'b0;
		end else if (fire) begin
			case (mode_s1)
				MODE_SET: begin
					if (playing_q) begin
						saved_pat_q <= pattern_s1;
					end else begin
						cur_pat_q <= pattern_s1;
					end
				end
				MODE_SHOW: begin
					saved_pat_q <= cur_pat_q;
					playing_q   <= 1'b1;
					cur_pat_q   <= PAT_FINGERPRINT;
				end
				MODE_TICK: begin
					led_q     <= led_next;
					playing_q <= playing_next;
					if (playing_q && morse_done) begin
						cur_pat_q <= saved_pat_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (is_tick) begin
			led_pin_q   <= active_high_q ? led_next : !led_next;
			fp_active_q <= playing_next;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b000000, fp_active_q, led_pin_q};

endmodule

// ===== hdl/slpm_checker.sv =====
// port-level checks for the status led driver, bound to the top level
`timescale 1ns / 1ps
module slpm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);
	import slpm_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	// input only backs up behind a full output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with output empty");

	// a tick transfer gives a result in the cycle after its stage moves
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tdata[1:0] == MODE_TICK)
			##1 (!m_tvalid || m_tready) |=> m_tvalid)
		else $error("tick transfer produced no result");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:2] == 6'b000000)
		else $error("output padding not zero");

endmodule

bind status_led_pattern_morse slpm_checker u_slpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/tb_status_led_pattern_morse.sv =====
// testbench for the status led pattern driver, checked against a cycle-free model of its led state
`timescale 1ns / 1ps
module tb_status_led_pattern_morse;
	import slpm_pkg::*;

	typedef struct packed {
		logic led_pin;
		logic fp_active;
	} led_result_t;

	localparam int MORSE_OFF  = 0;
	localparam int MORSE_ON   = 1;
	localparam int MORSE_DONE = 2;
	localparam int PHASE_PERIOD = 600;

	// symbol bits and symbol counts per nibble, nibble 0 in the low bits
	localparam logic [79:0] MORSE_SYMS = {5'h02, 5'h00, 5'h04, 5'h0A, 5'h08, 5'h01, 5'h1E, 5'h1C,
		5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F, 5'h1F};
	localparam logic [47:0] MORSE_LENS = {3'd4, 3'd1, 3'd3, 3'd4, 3'd4, 3'd2, 3'd5, 3'd5,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;    // mode, pattern, fingerprint, zero pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;    // led_pin, fingerprint_active, zero pad

	// led driver state as the block should hold it
	logic        polarity_high;
	logic [3:0]  cur_pattern;
	logic [3:0]  held_pattern;
	int unsigned phase_cnt;
	logic        morse_running;
	int          morse_offset;
	logic [31:0] fp_code;
	logic        led_state;

	led_result_t led_results_q[$];
	led_result_t want;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int mismatch_count = 0;
	int items_sent = 0;

	status_led_pattern_morse i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #6 clk = ~clk;

	function automatic int morse_level(input logic [31:0] fp, input int t);
		int cursor;
		int on;
		int len;
		logic [3:0] nib;
		logic [4:0] syms;
		cursor = 0;
		for (int i = 0; i < 8; i++) begin
			nib = fp[31 - 4 * i -: 4];
			syms = MORSE_SYMS[nib * 5 +: 5];
			len = MORSE_LENS[nib * 3 +: 3];
			for (int b = len - 1; b >= 0; b--) begin
				on = syms[b] ? int'(DAH_TICKS) : int'(DIT_TICKS);
				if (t < cursor + on) return MORSE_ON;
				cursor += on;
				if (t < cursor + int'(SYM_GAP)) return MORSE_OFF;
				cursor += int'(SYM_GAP);
			end
			if (t < cursor + int'(CHAR_GAP)) return MORSE_OFF;
			cursor += int'(CHAR_GAP);
		end
		if (t < cursor + int'(FINAL_GAP)) return MORSE_OFF;
		return MORSE_DONE;
	endfunction

	function automatic logic pattern_on(input logic [3:0] p, input int unsigned t,
		input logic held);
		int unsigned ph;
		case (p)
			PAT_SOLID: return 1'b1;
			PAT_SLOW: return (t % 200) < 20;
			PAT_FAST: return (t % 40) < 20;
			PAT_DOUBLE: begin
				ph = t % 200;
				return ph < 20 || (ph >= 40 && ph < 60);
			end
			PAT_TRIPLE: begin
				ph = t % 300;
				return ph < 20 || (ph >= 40 && ph < 60) || (ph >= 80 && ph < 100);
			end
			PAT_HEARTBEAT: begin
				ph = t % 120;
				return ph < 10 || (ph >= 20 && ph < 30);
			end
			PAT_ERROR: return (t % 30) < 15;
			PAT_FINGERPRINT: return held;
			default: return 1'b0;
		endcase
	endfunction

	task automatic update_led_state(input mode_t mode, input logic [3:0] pat,
		input logic [31:0] fp);
		int lv;
		led_result_t r;
		case (mode)
			MODE_SET: begin
				if (morse_running) held_pattern = pat;
				else cur_pattern = pat;
				phase_cnt = 0;
			end
			MODE_SHOW: begin
				fp_code = fp;
				held_pattern = cur_pattern;
				morse_running = 1'b1;
				morse_offset = 0;
				cur_pattern = PAT_FINGERPRINT;
			end
			MODE_TICK: begin
				if (morse_running) begin
					lv = morse_level(fp_code, morse_offset);
					if (lv == MORSE_DONE) begin
						morse_running = 1'b0;
						cur_pattern = held_pattern;
						led_state = 1'b0;
					end else begin
						led_state = (lv == MORSE_ON);
						morse_offset++;
					end
				end else begin
					led_state = pattern_on(cur_pattern, phase_cnt, led_state);
					phase_cnt = (phase_cnt + 1) % PHASE_PERIOD;
				end
				r.led_pin = polarity_high ? led_state : ~led_state;
				r.fp_active = morse_running;
				led_results_q.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input int expv, input int gotv);
		$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, expv, gotv);
		mismatch_count++;
	endtask

	// result check and receiver stalls
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (led_results_q.size() == 0) begin
				report_mismatch("transfer with nothing expected", 0, m_tdata);
			end else begin
				want = led_results_q.pop_front();
				if (m_tdata[0] !== want.led_pin)
					report_mismatch("led_pin", want.led_pin, m_tdata[0]);
				if (m_tdata[1] !== want.fp_active)
					report_mismatch("fingerprint_active", want.fp_active, m_tdata[1]);
			end
		end
		m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	task automatic send_item(input mode_t mode, input logic [3:0] pat, input logic [31:0] fp);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, fp, pat, mode};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		update_led_state(mode, pat, fp);
	endtask

	task automatic send_tick();
		send_item(MODE_TICK, 4'($urandom), $urandom);
	endtask

	function automatic logic [3:0] random_pattern();
		if ($urandom_range(0, 3) == 0) return 4'($urandom);
		return 4'($urandom_range(1, 8));
	endfunction

	// mostly single-dit nibbles so playback stays short
	function automatic logic [31:0] short_fingerprint();
		logic [31:0] fp;
		for (int i = 0; i < 8; i++)
			fp[4 * i +: 4] = ($urandom_range(0, 99) < 70) ? 4'hE : 4'($urandom);
		return fp;
	endfunction

	task automatic play_to_end(input bit with_set, input int max_items);
		int k;
		int n;
		k = $urandom_range(0, 300);
		n = 0;
		while (morse_running && n < max_items) begin
			if (with_set && n == k) send_item(MODE_SET, random_pattern(), $urandom);
			else send_tick();
			n++;
		end
	endtask

	task automatic finish_phase();
		s_tvalid <= 1'b0;
		while (led_results_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_polarity(input logic v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		polarity_high = v;
	endtask

	task automatic set_pace(input int tx, input int rx);
		tx_idle_pct = tx;
		rx_stall_pct = rx;
	endtask

	task automatic test_directed();
		send_tick();
		for (int p = 0; p <= 7; p++) begin
			send_item(MODE_SET, 4'(p), $urandom);
			send_tick();
		end
		send_item(MODE_SET, 4'hF, $urandom);
		send_tick();
		send_item(MODE_RSVD, 4'($urandom), $urandom);
		send_item(MODE_SET, PAT_FINGERPRINT, 32'h0);
		send_tick();
		send_item(MODE_SHOW, 4'($urandom), 32'hFFFFFFFF);
		send_tick();
		send_item(MODE_SET, PAT_FAST, $urandom);
		send_item(MODE_SHOW, 4'($urandom), 32'hEEEEEEEE);
		send_tick();
	endtask

	// nested show leaves the fingerprint pattern saved, so the led holds after playback
	task automatic test_nested_hold();
		play_to_end(1'b0, 4000);
		repeat (20) send_tick();
	endtask

	// saved pattern resumes at its old phase, and the phase counter wraps
	task automatic test_resume_and_wrap();
		send_item(MODE_SET, 4'($urandom_range(int'(PAT_SLOW), int'(PAT_ERROR))), $urandom);
		repeat (350) send_tick();
		send_item(MODE_SHOW, 4'($urandom), 32'hEEEEEEEE);
		play_to_end(1'b0, 4000);
		repeat (260) send_tick();
	endtask

	task automatic test_random_traffic(input int quota);
		int first;
		int r;
		first = items_sent;
		while (items_sent - first < quota) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				repeat ($urandom_range(1, 24)) send_tick();
			end else if (r < 55) begin
				send_item(MODE_SET, random_pattern(), $urandom);
			end else if (r < 62) begin
				send_item(MODE_RSVD, 4'($urandom), $urandom);
			end else if (r < 74) begin
				send_item(MODE_SHOW, 4'($urandom),
					$urandom_range(0, 1) ? short_fingerprint() : $urandom);
			end else if (r < 79) begin
				play_to_end(1'($urandom_range(0, 1)), quota - (items_sent - first));
			end else begin
				repeat ($urandom_range(2, 8))
					send_item(mode_t'($urandom_range(0, 3)), 4'($urandom), short_fingerprint());
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		polarity_high = 1'b1;
		cur_pattern = PAT_OFF;
		held_pattern = PAT_OFF;
		phase_cnt = 0;
		morse_running = 1'b0;
		morse_offset = 0;
		fp_code = '0;
		led_state = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_pace(0, 0);
		test_directed();
		finish_phase();
		write_polarity(1'b0);

		set_pace(53, 0);
		test_nested_hold();
		finish_phase();
		write_polarity(1'b1);

		set_pace(0, 53);
		test_resume_and_wrap();
		finish_phase();
		write_polarity(1'b0);

		set_pace(23, 23);
		test_random_traffic(85);
		finish_phase();
		write_polarity(1'b1);

		set_pace(0, 0);
		test_random_traffic(85);
		finish_phase();
		write_polarity(1'b0);

		set_pace(53, 0);
		test_random_traffic(85);
		finish_phase();
		write_polarity(1'b1);

		set_pace(0, 53);
		test_random_traffic(85);
		finish_phase();

		if (mismatch_count == 0 && led_results_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/slpm_pkg.sv
hdl/slpm_pattern_gen.sv
hdl/slpm_morse_seq.sv
hdl/status_led_pattern_morse.sv
hdl/slpm_checker.sv
tb/tb_status_led_pattern_morse.sv
